### rtl/core/assert_macros.svh
// Assertion macros shared by the core modules.
// Each expects signals named clk and arst_n in the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/tlna_pkg.sv
package tlna_pkg;

	localparam int NUMBER_WIDTH = 6;
	localparam int DIGIT_W      = 4;

	localparam int BYTE_W      = 8;
	localparam int CFG_INDEX_W = 8;
	localparam int CFG_DATA_W  = 8;

	// Output slots of one run: the digits, then tab, dollar, caret, final byte.
	localparam int SLOT_COUNT = NUMBER_WIDTH + 4;
	localparam int SLOT_W     = $clog2(SLOT_COUNT);

	localparam logic [SLOT_W-1:0] SLOT_FIRST_DIGIT = '0;
	localparam logic [SLOT_W-1:0] SLOT_TAB         = SLOT_W'(NUMBER_WIDTH);
	localparam logic [SLOT_W-1:0] SLOT_DOLLAR      = SLOT_W'(NUMBER_WIDTH + 1);
	localparam logic [SLOT_W-1:0] SLOT_CARET       = SLOT_W'(NUMBER_WIDTH + 2);
	localparam logic [SLOT_W-1:0] SLOT_BYTE        = SLOT_W'(NUMBER_WIDTH + 3);

	localparam logic [BYTE_W-1:0] CHAR_NL     = 8'h0A;
	localparam logic [BYTE_W-1:0] CHAR_TAB    = 8'h09;
	localparam logic [BYTE_W-1:0] CHAR_SPACE  = 8'h20;
	localparam logic [BYTE_W-1:0] CHAR_DOLLAR = 8'h24;
	localparam logic [BYTE_W-1:0] CHAR_CARET  = 8'h5E;
	localparam logic [BYTE_W-1:0] CHAR_I      = 8'h49;
	localparam logic [BYTE_W-1:0] CHAR_ZERO   = 8'h30;

	localparam logic [CFG_INDEX_W-1:0] REG_MARK_LINE_ENDS       = 8'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_NUMBER_NONBLANK_ONLY = 8'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_NUMBER_ALL_LINES     = 8'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_SHOW_TAB_MARKS       = 8'd3;

	// Index 0 is the most significant digit.
	typedef logic [NUMBER_WIDTH-1:0][DIGIT_W-1:0] digits_t;

	localparam digits_t DIGITS_ONE = {DIGIT_W'(1), {((NUMBER_WIDTH - 1) * DIGIT_W){1'b0}}};

	typedef struct packed {
		digits_t                 digits;
		logic [NUMBER_WIDTH-1:0] blank;
		logic                    line_start;
	} count_view_t;

	typedef struct packed {
		logic [BYTE_W-1:0]       text_byte;
		logic                    numbered;
		logic                    dollar;
		logic                    tab_mark;
		digits_t                 digits;
		logic [NUMBER_WIDTH-1:0] blank;
	} item_t;

endpackage

### rtl/core/tlna_in_if.sv
interface tlna_in_if;
	logic                           valid;
	logic                           ready;
	logic [tlna_pkg::BYTE_W-1:0]    text_byte;
	logic                           file_start;

	modport source (output valid, output text_byte, output file_start, input ready);
	modport sink (input valid, input text_byte, input file_start, output ready);
endinterface

### rtl/core/tlna_out_if.sv
interface tlna_out_if;
	logic                           valid;
	logic                           ready;
	logic [tlna_pkg::BYTE_W-1:0]    out_byte;
	logic                           run_last;

	modport source (output valid, output out_byte, output run_last, input ready);
	modport sink (input valid, input out_byte, input run_last, output ready);
endinterface

### rtl/core/tlna_cfg_if.sv
interface tlna_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [tlna_pkg::CFG_INDEX_W-1:0]  index;
	logic [tlna_pkg::CFG_DATA_W-1:0]   data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

### rtl/core/tlna_counter.sv
`include "assert_macros.svh"

module tlna_counter (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        accept,
	input  logic [tlna_pkg::BYTE_W-1:0] text_byte,
	input  logic                        file_start,
	input  logic                        number_nonblank_only,
	output tlna_pkg::count_view_t       view
);

	tlna_pkg::digits_t digits_q;
	logic              at_line_start_q;
	tlna_pkg::digits_t digits_eff;
	logic              line_start_eff;
	logic              is_nl;
	logic              digits_ok;

	function automatic tlna_pkg::digits_t bcd_next(tlna_pkg::digits_t d);
		tlna_pkg::digits_t r;
		logic              carry;
		logic              sat;
		r     = d;
		carry = 1'b1;
		sat   = 1'b1;
		for (int i = 0; i < tlna_pkg::NUMBER_WIDTH; i++) begin
			if (d[i] != 4'd9) begin
				sat = 1'b0;
			end
		end
		for (int i = tlna_pkg::NUMBER_WIDTH - 1; i >= 0; i--) begin
			if (carry) begin
				if (d[i] >= 4'd9) begin
					r[i] = 4'd0;
				end else begin
					r[i]  = d[i] + 4'd1;
					carry = 1'b0;
				end
			end
		end
		if (sat) begin
			r = d;
		end
		return r;
	endfunction

	// A new file restarts the count and opens a line before this byte is seen.
	assign digits_eff     = file_start ? tlna_pkg::DIGITS_ONE : digits_q;
	assign line_start_eff = file_start | at_line_start_q;
	assign is_nl          = (text_byte == tlna_pkg::CHAR_NL);

	always_comb begin
		logic lead;
		lead            = 1'b1;
		view.digits     = digits_eff;
		view.line_start = line_start_eff;
		for (int i = 0; i < tlna_pkg::NUMBER_WIDTH; i++) begin
			lead          = lead & (digits_eff[i] == 4'd0);
			view.blank[i] = lead && (i != tlna_pkg::NUMBER_WIDTH - 1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digits_q        <= tlna_pkg::DIGITS_ONE;
			at_line_start_q <= 1'b1;
		end else if (accept) begin
			if (is_nl) begin
				// In nonblank mode a blank line is left unnumbered and does not advance the count.
				if (!(number_nonblank_only && line_start_eff)) begin
					digits_q <= bcd_next(digits_eff);
				end else begin
					digits_q <= digits_eff;
				end
				at_line_start_q <= 1'b1;
			end else begin
				digits_q        <= digits_eff;
				at_line_start_q <= 1'b0;
			end
		end
	end

	always_comb begin
		digits_ok = 1'b1;
		for (int i = 0; i < tlna_pkg::NUMBER_WIDTH; i++) begin
			if (digits_q[i] > 4'd9) begin
				digits_ok = 1'b0;
			end
		end
	end

	`ASSERT_ALWAYS(a_digits_bcd, digits_ok, "line count holds a digit above nine")
	`ASSERT_NEXT(a_file_restart, accept && file_start && !is_nl, digits_q == tlna_pkg::DIGITS_ONE && !at_line_start_q, "new file did not restart the count")

endmodule

### rtl/core/tlna_emitter.sv
`include "assert_macros.svh"

module tlna_emitter (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_load,
	input  tlna_pkg::item_t             item,
	output logic                        in_ready,
	input  logic                        out_ready,
	output logic                        out_valid,
	output logic [tlna_pkg::BYTE_W-1:0] out_byte,
	output logic                        run_last
);

	logic                        valid_s1;
	tlna_pkg::item_t             item_s1;
	logic [tlna_pkg::SLOT_W-1:0] pos_s1;

	logic                        out_valid_q;
	logic [tlna_pkg::BYTE_W-1:0] out_byte_q;
	logic                        out_last_q;

	logic                        out_load;
	logic                        emit_last;
	logic [tlna_pkg::BYTE_W-1:0] slot_byte;

	// Slot after the number (or the first slot of an unnumbered run).
	function automatic logic [tlna_pkg::SLOT_W-1:0] after_number(tlna_pkg::item_t it);
		if (it.dollar) begin
			return tlna_pkg::SLOT_DOLLAR;
		end else if (it.tab_mark) begin
			return tlna_pkg::SLOT_CARET;
		end else begin
			return tlna_pkg::SLOT_BYTE;
		end
	endfunction

	function automatic logic [tlna_pkg::SLOT_W-1:0] start_slot(tlna_pkg::item_t it);
		return it.numbered ? tlna_pkg::SLOT_FIRST_DIGIT : after_number(it);
	endfunction

	function automatic logic [tlna_pkg::SLOT_W-1:0] next_slot(
		logic [tlna_pkg::SLOT_W-1:0] pos,
		tlna_pkg::item_t             it
	);
		priority if (pos < tlna_pkg::SLOT_TAB) begin
			return pos + 1'b1;
		end else if (pos == tlna_pkg::SLOT_TAB) begin
			return after_number(it);
		end else if (pos == tlna_pkg::SLOT_DOLLAR) begin
			return it.tab_mark ? tlna_pkg::SLOT_CARET : tlna_pkg::SLOT_BYTE;
		end else begin
			return tlna_pkg::SLOT_BYTE;
		end
	endfunction

	always_comb begin
		logic [tlna_pkg::DIGIT_W-1:0] digit;
		logic                         blank;
		digit = '0;
		blank = 1'b0;
		for (int i = 0; i < tlna_pkg::NUMBER_WIDTH; i++) begin
			if (pos_s1 == tlna_pkg::SLOT_W'(i)) begin
				digit = item_s1.digits[i];
				blank = item_s1.blank[i];
			end
		end
		priority if (pos_s1 < tlna_pkg::SLOT_TAB) begin
			slot_byte = blank ? tlna_pkg::CHAR_SPACE
				: (tlna_pkg::CHAR_ZERO | {{(tlna_pkg::BYTE_W - tlna_pkg::DIGIT_W){1'b0}}, digit});
		end else if (pos_s1 == tlna_pkg::SLOT_TAB) begin
			slot_byte = tlna_pkg::CHAR_TAB;
		end else if (pos_s1 == tlna_pkg::SLOT_DOLLAR) begin
			slot_byte = tlna_pkg::CHAR_DOLLAR;
		end else if (pos_s1 == tlna_pkg::SLOT_CARET) begin
			slot_byte = tlna_pkg::CHAR_CARET;
		end else begin
			slot_byte = item_s1.tab_mark ? tlna_pkg::CHAR_I : item_s1.text_byte;
		end
	end

	assign out_load  = valid_s1 && (!out_valid_q || out_ready);
	assign emit_last = (pos_s1 == tlna_pkg::SLOT_BYTE);
	// The stage takes a new word when empty or in the cycle its last byte moves out.
	assign in_ready  = !valid_s1 || (out_load && emit_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			pos_s1   <= '0;
		end else if (in_load) begin
			valid_s1 <= 1'b1;
			pos_s1   <= start_slot(item);
		end else if (out_load && emit_last) begin
			valid_s1 <= 1'b0;
		end else if (out_load) begin
			pos_s1 <= next_slot(pos_s1, item_s1);
		end
	end

	always_ff @(posedge clk) begin
		if (in_load) begin
			item_s1 <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_byte_q <= slot_byte;
			out_last_q <= emit_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign run_last  = out_last_q;

	`ASSERT_NEXT(a_pos_hold, valid_s1 && !out_load, valid_s1 && $stable(pos_s1), "run position moved while output was full")
	`ASSERT_NEXT(a_run_done, out_load && emit_last && !in_load, !valid_s1, "stage still busy after its last byte")
	`ASSERT_IMPLIES(a_load_free, in_load, !valid_s1 || emit_last, "new word loaded over an unfinished run")

endmodule

### rtl/core/text_line_number_annotator_core.sv
// Channel  Role    Payload                         Handshake
// in_ch    sink    text_byte[7:0], file_start      valid/ready
// out_ch   source  out_byte[7:0], run_last         valid/ready
// cfg_ch   sink    index[7:0], data[7:0] (bit 0)   valid/ready, ready always high
//
// Each input word becomes a run of output bytes, one byte per cycle unless stalled:
// one for an ordinary byte, two for a tab shown as caret-I, one more for a dollar
// mark and NUMBER_WIDTH + 1 more for a line number, so that a run is at most
// NUMBER_WIDTH + 3 bytes. The run register takes a new word in the cycle its last
// byte enters the output register, so ordinary bytes stream at one per cycle unless
// stalled. A stalled output holds the run register and the input. Reset clears the
// count to one, opens a line and clears all four configuration bits.

module text_line_number_annotator_core (
	input  logic              clk,
	input  logic              arst_n,
	tlna_in_if.sink           in_ch,
	tlna_out_if.source        out_ch,
	tlna_cfg_if.sink          cfg_ch
);

	logic                  mark_line_ends_q;
	logic                  number_nonblank_only_q;
	logic                  number_all_lines_q;
	logic                  show_tab_marks_q;

	logic                  in_load;
	logic                  is_nl;
	tlna_pkg::count_view_t view;
	tlna_pkg::item_t       item;

	assign cfg_ch.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mark_line_ends_q       <= 1'b0;
			number_nonblank_only_q <= 1'b0;
			number_all_lines_q     <= 1'b0;
			show_tab_marks_q       <= 1'b0;
		end else if (cfg_ch.valid) begin
			unique case (cfg_ch.index)
				tlna_pkg::REG_MARK_LINE_ENDS:       mark_line_ends_q       <= cfg_ch.data[0];
				tlna_pkg::REG_NUMBER_NONBLANK_ONLY: number_nonblank_only_q <= cfg_ch.data[0];
				tlna_pkg::REG_NUMBER_ALL_LINES:     number_all_lines_q     <= cfg_ch.data[0];
				tlna_pkg::REG_SHOW_TAB_MARKS:       show_tab_marks_q       <= cfg_ch.data[0];
				default: begin
				end
			endcase
		end
	end

	assign in_load = in_ch.valid && in_ch.ready;
	assign is_nl   = (in_ch.text_byte == tlna_pkg::CHAR_NL);

	tlna_counter u_counter (
		.clk                  (clk),
		.arst_n               (arst_n),
		.accept               (in_load),
		.text_byte            (in_ch.text_byte),
		.file_start           (in_ch.file_start),
		.number_nonblank_only (number_nonblank_only_q),
		.view                 (view)
	);

	// Nonblank numbering overrides numbering of all lines.
	assign item.text_byte = in_ch.text_byte;
	assign item.numbered  = view.line_start
		&& (number_nonblank_only_q ? !is_nl : number_all_lines_q);
	assign item.dollar    = is_nl && mark_line_ends_q;
	assign item.tab_mark  = (in_ch.text_byte == tlna_pkg::CHAR_TAB) && show_tab_marks_q;
	assign item.digits    = view.digits;
	assign item.blank     = view.blank;

	tlna_emitter u_emitter (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_load   (in_load),
		.item      (item),
		.in_ready  (in_ch.ready),
		.out_ready (out_ch.ready),
		.out_valid (out_ch.valid),
		.out_byte  (out_ch.out_byte),
		.run_last  (out_ch.run_last)
	);

endmodule

### tb/tb.sv
module tb;

	localparam int CYCLE_LIMIT = 5_000_000;
	localparam int PRINT_LIMIT = 40;
	localparam int TAIL_CYCLES = 24;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_WORDS = 62;
	localparam int NEWLINE_RUN = 3;

	// An index that decodes to no register; writes to it must change nothing.
	localparam logic [tlna_pkg::CFG_INDEX_W-1:0] REG_SPARE = 8'hA5;

	// Bit i of a setting is the value written to register index i.
	localparam logic [3:0] SET_PLAIN    = 4'b0000;
	localparam logic [3:0] SET_TABS     = 4'b1000;
	localparam logic [3:0] SET_FULL     = 4'b1101;
	localparam logic [3:0] SET_NONBLANK = 4'b0111;
	localparam logic [3:0] SET_ALL_ON   = 4'b1111;

	typedef struct packed {
		logic [tlna_pkg::BYTE_W-1:0] out_byte;
		logic                        run_last;
	} annotated_t;

	typedef struct {
		logic [3:0]                  setting;
		logic [tlna_pkg::BYTE_W-1:0] text;
		logic                        file_start;
		int                          reps;
		string                       typed_run;
	} dir_row_t;

	// The newline row restarts the count and then advances it to four.
	dir_row_t dir_rows [25] = '{
		'{SET_PLAIN,    "A",                1'b0, 1, "A"},
		'{SET_PLAIN,    tlna_pkg::CHAR_TAB, 1'b0, 1, "\t"},
		'{SET_PLAIN,    8'h00,              1'b0, 1, ""},
		'{SET_PLAIN,    8'hFF,              1'b0, 1, ""},
		'{SET_PLAIN,    tlna_pkg::CHAR_NL,  1'b0, 1, "\n"},
		'{SET_FULL,     tlna_pkg::CHAR_TAB, 1'b1, 1, "     1\t^I"},
		'{SET_FULL,     tlna_pkg::CHAR_NL,  1'b0, 1, "$\n"},
		'{SET_FULL,     tlna_pkg::CHAR_NL,  1'b0, 1, "     2\t$\n"},
		'{SET_FULL,     "x",                1'b0, 1, "     3\tx"},
		'{SET_TABS,     tlna_pkg::CHAR_TAB, 1'b0, 1, "^I"},
		'{SET_TABS,     tlna_pkg::CHAR_NL,  1'b0, 1, "\n"},
		'{SET_NONBLANK, tlna_pkg::CHAR_NL,  1'b1, 1, "$\n"},
		'{SET_NONBLANK, "a",                1'b0, 1, "     1\ta"},
		'{SET_NONBLANK, tlna_pkg::CHAR_NL,  1'b0, 1, "$\n"},
		'{SET_NONBLANK, tlna_pkg::CHAR_NL,  1'b0, 1, "$\n"},
		'{SET_NONBLANK, tlna_pkg::CHAR_TAB, 1'b0, 1, "     2\t\t"},
		'{SET_NONBLANK, tlna_pkg::CHAR_NL,  1'b0, 1, "$\n"},
		'{SET_PLAIN,    tlna_pkg::CHAR_NL,  1'b1, NEWLINE_RUN, ""},
		'{SET_ALL_ON,   "q",                1'b0, 1, "     4\tq"},
		'{SET_ALL_ON,   tlna_pkg::CHAR_NL,  1'b0, 1, "$\n"},
		'{SET_FULL,     tlna_pkg::CHAR_NL,  1'b0, 1, "     5\t$\n"},
		'{SET_FULL,     "k",                1'b0, 1, "     6\tk"},
		'{SET_FULL,     "z",                1'b1, 1, "     1\tz"},
		'{SET_FULL,     8'h80,              1'b0, 1, ""},
		'{SET_FULL,     tlna_pkg::CHAR_NL,  1'b0, 1, "$\n"}
	};

	logic clk;
	logic arst_n;

	tlna_in_if  in_ch ();
	tlna_out_if out_ch ();
	tlna_cfg_if cfg_ch ();

	text_line_number_annotator_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.cfg_ch (cfg_ch)
	);

	// Predictor state: the line count as decimal digits, most significant first.
	logic [3:0]                  line_count [tlna_pkg::NUMBER_WIDTH];
	logic                        at_line_head;
	logic                        set_dollar;
	logic                        set_nonblank;
	logic                        set_all;
	logic                        set_tabmarks;
	logic [tlna_pkg::BYTE_W-1:0] annotated_run [$];
	annotated_t                  annotated_q [$];
	annotated_t                  oldest;

	int  mismatches;
	int  cycle_count;
	int  stall_left;
	logic rx_steady;
	logic tx_steady;

	initial clk = 1'b0;
	always #10 clk = ~clk;

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 40);
	endfunction

	function automatic void restart_count();
		int i;
		for (i = 0; i < tlna_pkg::NUMBER_WIDTH; i++)
			line_count[i] = 4'd0;
		line_count[tlna_pkg::NUMBER_WIDTH-1] = 4'd1;
	endfunction

	// Fills annotated_run with the bytes that one input word should produce.
	function automatic void annotate_byte(input logic [tlna_pkg::BYTE_W-1:0] b, input logic fs);
		logic nl;
		logic leading;
		logic carry;
		int   i;
		nl = (b == tlna_pkg::CHAR_NL);
		annotated_run = {};
		if (fs) begin
			restart_count();
			at_line_head = 1'b1;
		end
		if (at_line_head && (set_nonblank ? !nl : set_all)) begin
			leading = 1'b1;
			for (i = 0; i < tlna_pkg::NUMBER_WIDTH; i++) begin
				if (leading && line_count[i] == 4'd0 && i != tlna_pkg::NUMBER_WIDTH - 1) begin
					annotated_run.push_back(tlna_pkg::CHAR_SPACE);
				end else begin
					leading = 1'b0;
					annotated_run.push_back(tlna_pkg::CHAR_ZERO
						+ tlna_pkg::BYTE_W'(line_count[i]));
				end
			end
			annotated_run.push_back(tlna_pkg::CHAR_TAB);
		end
		if (nl && set_dollar)
			annotated_run.push_back(tlna_pkg::CHAR_DOLLAR);
		if (b == tlna_pkg::CHAR_TAB && set_tabmarks) begin
			annotated_run.push_back(tlna_pkg::CHAR_CARET);
			annotated_run.push_back(tlna_pkg::CHAR_I);
		end else begin
			annotated_run.push_back(b);
		end
		if (nl) begin
			// A blank line in nonblank mode is not numbered and does not count.
			if (!(set_nonblank && at_line_head)) begin
				carry = 1'b0;
				for (i = 0; i < tlna_pkg::NUMBER_WIDTH; i++)
					if (line_count[i] != 4'd9)
						carry = 1'b1;
				for (i = tlna_pkg::NUMBER_WIDTH - 1; i >= 0; i--) begin
					if (carry) begin
						if (line_count[i] == 4'd9) begin
							line_count[i] = 4'd0;
						end else begin
							line_count[i] = line_count[i] + 4'd1;
							carry = 1'b0;
						end
					end
				end
			end
			at_line_head = 1'b1;
		end else begin
			at_line_head = 1'b0;
		end
	endfunction

	task automatic report_mismatch(input string msg);
		mismatches++;
		if (mismatches <= PRINT_LIMIT)
			$display("mismatch %0d at cycle %0d: %s", mismatches, cycle_count, msg);
	endtask

	// Leaves valid high on return; the caller lowers it once the batch is done.
	task automatic write_reg(input logic [tlna_pkg::CFG_INDEX_W-1:0] idx, input logic value);
		logic [tlna_pkg::CFG_DATA_W-1:0] data;
		data = {(tlna_pkg::CFG_DATA_W - 1)'($urandom_range(0, 127)), value};
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= data;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		case (idx)
			tlna_pkg::REG_MARK_LINE_ENDS:       set_dollar   = data[0];
			tlna_pkg::REG_NUMBER_NONBLANK_ONLY: set_nonblank = data[0];
			tlna_pkg::REG_NUMBER_ALL_LINES:     set_all      = data[0];
			tlna_pkg::REG_SHOW_TAB_MARKS:       set_tabmarks = data[0];
			default: ;
		endcase
	endtask

	task automatic wait_drained();
		while (annotated_q.size() != 0)
			@(posedge clk);
	endtask

	// Registers are only written with nothing in flight.
	task automatic apply_settings(input logic [3:0] s);
		in_ch.valid <= 1'b0;
		wait_drained();
		write_reg(tlna_pkg::REG_MARK_LINE_ENDS, s[0]);
		write_reg(tlna_pkg::REG_NUMBER_NONBLANK_ONLY, s[1]);
		write_reg(tlna_pkg::REG_SHOW_TAB_MARKS, s[3]);
		write_reg(REG_SPARE, 1'($urandom_range(0, 1)));
		write_reg(tlna_pkg::REG_NUMBER_ALL_LINES, s[2]);
		cfg_ch.valid <= 1'b0;
	endtask

	// Offers one word, waits for it to be taken, then records what it should produce.
	task automatic send_word(input logic [tlna_pkg::BYTE_W-1:0] b, input logic fs,
			input string typed, input logic no_gap);
		int j;
		int gap;
		in_ch.valid      <= 1'b1;
		in_ch.text_byte  <= b;
		in_ch.file_start <= fs;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		annotate_byte(b, fs);
		if (typed.len() != 0) begin
			annotated_run = {};
			for (j = 0; j < typed.len(); j++)
				annotated_run.push_back(typed[j]);
		end
		for (j = 0; j < annotated_run.size(); j++)
			annotated_q.push_back('{annotated_run[j], j == annotated_run.size() - 1});
		gap = no_gap ? 0 : pick_gap();
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Output side: checks accepted bytes; drives ready steadily or with random stalls.
	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (annotated_q.size() == 0) begin
				report_mismatch($sformatf("unexpected byte %h", out_ch.out_byte));
			end else begin
				oldest = annotated_q.pop_front();
				if (out_ch.out_byte !== oldest.out_byte)
					report_mismatch($sformatf("out_byte %h, want %h",
						out_ch.out_byte, oldest.out_byte));
				if (out_ch.run_last !== oldest.run_last)
					report_mismatch($sformatf("run_last %b, want %b on byte %h",
						out_ch.run_last, oldest.run_last, oldest.out_byte));
			end
		end
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else if (rx_steady) begin
			out_ch.ready <= 1'b1;
		end else if (stall_left > 0) begin
			out_ch.ready <= 1'b0;
			stall_left--;
		end else begin
			out_ch.ready <= 1'b1;
			stall_left = pick_gap();
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		int r;
		int k;
		int p;
		int pick;
		logic [tlna_pkg::BYTE_W-1:0] b;
		logic [3:0] s;

		mismatches       = 0;
		cycle_count      = 0;
		stall_left       = 0;
		rx_steady        = 1'b0;
		tx_steady        = 1'b0;
		arst_n           = 1'b0;
		in_ch.valid      = 1'b0;
		in_ch.text_byte  = '0;
		in_ch.file_start = 1'b0;
		out_ch.ready     = 1'b0;
		cfg_ch.valid     = 1'b0;
		cfg_ch.index     = '0;
		cfg_ch.data      = '0;
		set_dollar       = 1'b0;
		set_nonblank     = 1'b0;
		set_all          = 1'b0;
		set_tabmarks     = 1'b0;
		at_line_head     = 1'b1;
		restart_count();

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (r = 0; r < $size(dir_rows); r++) begin
			if (r == 0 || dir_rows[r].setting != dir_rows[r-1].setting)
				apply_settings(dir_rows[r].setting);
			// The repeated newline row streams back to back.
			rx_steady = (dir_rows[r].reps > 1);
			for (k = 0; k < dir_rows[r].reps; k++)
				send_word(dir_rows[r].text, dir_rows[r].file_start && k == 0,
					dir_rows[r].typed_run, dir_rows[r].reps > 1);
		end
		rx_steady = 1'b0;

		for (p = 0; p < RANDOM_PHASES; p++) begin
			if (p == 0)
				s = SET_ALL_ON;
			else if (p == 1)
				s = SET_PLAIN;
			else
				s = 4'($urandom_range(0, 15));
			apply_settings(s);
			tx_steady = ($urandom_range(0, 3) == 0);
			rx_steady = ($urandom_range(0, 3) == 0);
			for (k = 0; k < PHASE_WORDS; k++) begin
				pick = $urandom_range(0, 99);
				if (pick < 22)
					b = tlna_pkg::CHAR_NL;
				else if (pick < 36)
					b = tlna_pkg::CHAR_TAB;
				else
					b = tlna_pkg::BYTE_W'($urandom_range(0, 255));
				send_word(b, $urandom_range(0, 19) == 0, "", tx_steady);
			end
		end
		rx_steady = 1'b0;

		in_ch.valid <= 1'b0;
		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

### files.f
+incdir+rtl/core
rtl/core/tlna_pkg.sv
rtl/core/tlna_in_if.sv
rtl/core/tlna_out_if.sv
rtl/core/tlna_cfg_if.sv
rtl/core/tlna_counter.sv
rtl/core/tlna_emitter.sv
rtl/core/text_line_number_annotator_core.sv
tb/tb.sv
